>>> sv/tmb_pkg.sv
// Package for the TRS model matrix builder: item types, CORDIC constants,
// fixed-point helpers. No dependencies.
package tmb_pkg;

    localparam int CordicSteps = 24;
    localparam logic signed [33:0] CordicGain = 34'sd652032874;
    localparam logic signed [31:0] OneQ16 = 32'sd65536;
    localparam logic signed [32:0] OneQ28 = 33'sd268435456;
    localparam logic ACT_EULER = 1'b0;
    localparam logic ACT_QUAT  = 1'b1;

    typedef struct packed {
        logic               action;
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
        logic signed [15:0] rot_a;
        logic signed [15:0] rot_b;
        logic signed [15:0] rot_c;
        logic signed [15:0] rot_d;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         column_index;
        logic signed [31:0] elem_row0;
        logic signed [31:0] elem_row1;
        logic signed [31:0] elem_row2;
        logic signed [31:0] elem_row3;
        logic               saturated;
        logic               last;
    } out_item_t;

    typedef logic signed [33:0] q30_t;
    typedef logic signed [36:0] q28_t;

    typedef struct packed {
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
        q28_t [8:0]         rot;
    } rot_item_t;

    function automatic logic signed [31:0] atan_turn(input logic [4:0] i);
        case (i)
            5'd0:  atan_turn = 32'sd536870912;
            5'd1:  atan_turn = 32'sd316933405;
            5'd2:  atan_turn = 32'sd167458907;
            5'd3:  atan_turn = 32'sd85004756;
            5'd4:  atan_turn = 32'sd42667331;
            5'd5:  atan_turn = 32'sd21354465;
            5'd6:  atan_turn = 32'sd10679838;
            5'd7:  atan_turn = 32'sd5340245;
            5'd8:  atan_turn = 32'sd2670163;
            5'd9:  atan_turn = 32'sd1335086;
            5'd10: atan_turn = 32'sd667544;
            5'd11: atan_turn = 32'sd333772;
            5'd12: atan_turn = 32'sd166886;
            5'd13: atan_turn = 32'sd83443;
            5'd14: atan_turn = 32'sd41721;
            5'd15: atan_turn = 32'sd20860;
            5'd16: atan_turn = 32'sd10430;
            5'd17: atan_turn = 32'sd5215;
            5'd18: atan_turn = 32'sd2607;
            5'd19: atan_turn = 32'sd1303;
            5'd20: atan_turn = 32'sd651;
            5'd21: atan_turn = 32'sd325;
            5'd22: atan_turn = 32'sd162;
            5'd23: atan_turn = 32'sd81;
            default: atan_turn = 32'sd0;
        endcase
    endfunction

    function automatic q30_t mul30(input q30_t a, input q30_t b);
        logic signed [67:0] p;
        p = a * b + 68'sd536870912;
        mul30 = q30_t'(p >>> 30);
    endfunction

    function automatic q28_t to_q28(input logic signed [35:0] v);
        logic signed [35:0] t;
        t = (v + 36'sd2) >>> 2;
        to_q28 = q28_t'(t);
    endfunction

endpackage

>>> sv/trs_model_matrix_builder_top.sv
// Top level of the TRS model matrix builder: front, queue and back parts.
// Uses tmb_pkg, tmb_front, tmb_queue, tmb_back.
// Each item yields four column items (0..3) on the output. A quaternion item
// passes from acceptance straight to the handoff in the front; an euler item
// passes there through a setup step, the 24-step CORDIC run for its three
// angles at once, the partial products, the rotation elements and the handoff.
// The back emits one column per cycle while the output is not stalled.
module trs_model_matrix_builder_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  tmb_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output tmb_pkg::out_item_t out_item
);

    logic f_valid, f_stall, b_valid, b_stall;
    tmb_pkg::rot_item_t f_item, b_item;

    tmb_front u_front (.clk, .rst_n, .in_valid, .in_stall, .in_item,
        .rq_valid(f_valid), .rq_stall(f_stall), .rq_item(f_item));
    tmb_queue u_queue (.clk, .rst_n, .wr_valid(f_valid), .wr_stall(f_stall),
        .wr_item(f_item), .rd_valid(b_valid), .rd_stall(b_stall), .rd_item(b_item));
    tmb_back u_back (.clk, .rst_n, .rq_valid(b_valid), .rq_stall(b_stall),
        .rq_item(b_item), .out_valid, .out_stall, .out_item);

endmodule

>>> sv/tmb_front.sv
// Front part: accepts items, runs three CORDIC units (one per angle) for
// euler items, forms quaternion rotation elements. Uses tmb_pkg.
module tmb_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tmb_pkg::in_item_t   in_item,
    output logic                rq_valid,
    input  logic                rq_stall,
    output tmb_pkg::rot_item_t  rq_item
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CORD = 2'd1;
    localparam logic [1:0] ST_PROD = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;
    localparam logic [4:0] CordLastStep = 5'(tmb_pkg::CordicSteps);
    localparam logic [4:0] CordDoneStep = 5'(tmb_pkg::CordicSteps + 1);

    logic [1:0]          state_reg, state_next;
    logic [4:0]          step_reg;
    tmb_pkg::in_item_t   item_reg;
    tmb_pkg::q30_t [2:0] x_reg, y_reg;
    logic signed [31:0]  z_reg [3];
    logic [2:0]          flip_reg;
    tmb_pkg::q30_t [1:0] p1_reg;
    tmb_pkg::rot_item_t  res_reg;

    tmb_pkg::q30_t sp, cp, sh, ch, sb, cb;
    logic signed [15:0] ang [3];
    logic accept;

    assign accept   = in_valid && !in_stall;
    assign in_stall = state_reg != ST_IDLE;
    assign rq_valid = state_reg == ST_DONE;
    assign rq_item  = res_reg;

    assign ang[0] = item_reg.rot_a;
    assign ang[1] = item_reg.rot_b;
    assign ang[2] = item_reg.rot_c;

    assign sp = flip_reg[0] ? -y_reg[0] : y_reg[0];
    assign cp = flip_reg[0] ? -x_reg[0] : x_reg[0];
    assign sh = flip_reg[1] ? -y_reg[1] : y_reg[1];
    assign ch = flip_reg[1] ? -x_reg[1] : x_reg[1];
    assign sb = flip_reg[2] ? -y_reg[2] : y_reg[2];
    assign cb = flip_reg[2] ? -x_reg[2] : x_reg[2];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid)
                state_next = (in_item.action == tmb_pkg::ACT_QUAT) ? ST_DONE : ST_CORD;
            ST_CORD: if (step_reg == CordDoneStep) state_next = ST_PROD;
            ST_PROD: state_next = ST_DONE;
            ST_DONE: if (!rq_stall) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    function automatic tmb_pkg::rot_item_t quat(input tmb_pkg::in_item_t it);
        logic signed [32:0] xx, yy, zz, xz, xy, yz, wx, wy, wz;
        tmb_pkg::rot_item_t r;
        xx = 33'(it.rot_a * it.rot_a); yy = 33'(it.rot_b * it.rot_b);
        zz = 33'(it.rot_c * it.rot_c); xz = 33'(it.rot_a * it.rot_c);
        xy = 33'(it.rot_a * it.rot_b); yz = 33'(it.rot_b * it.rot_c);
        wx = 33'(it.rot_d * it.rot_a); wy = 33'(it.rot_d * it.rot_b);
        wz = 33'(it.rot_d * it.rot_c);
        r = '0;
        r.trans_x = it.trans_x; r.trans_y = it.trans_y; r.trans_z = it.trans_z;
        r.scale_x = it.scale_x; r.scale_y = it.scale_y; r.scale_z = it.scale_z;
        r.rot[0] = 37'(tmb_pkg::OneQ28) - 37'((37'(yy) + 37'(zz)) <<< 1);
        r.rot[1] = 37'((37'(xy) + 37'(wz)) <<< 1);
        r.rot[2] = 37'((37'(xz) - 37'(wy)) <<< 1);
        r.rot[3] = 37'((37'(xy) - 37'(wz)) <<< 1);
        r.rot[4] = 37'(tmb_pkg::OneQ28) - 37'((37'(xx) + 37'(zz)) <<< 1);
        r.rot[5] = 37'((37'(yz) + 37'(wx)) <<< 1);
        r.rot[6] = 37'((37'(xz) + 37'(wy)) <<< 1);
        r.rot[7] = 37'((37'(yz) - 37'(wx)) <<< 1);
        r.rot[8] = 37'(tmb_pkg::OneQ28) - 37'((37'(xx) + 37'(yy)) <<< 1);
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
            step_reg <= 5'd0;
            if (in_item.action == tmb_pkg::ACT_QUAT)
                res_reg <= quat(in_item);
            else
                res_reg <= quat(in_item);
        end
        if (state_reg == ST_CORD)
        begin
            step_reg <= step_reg + 5'd1;
            for (int k = 0; k < 3; k++)
            begin
                if (step_reg == 5'd0)
                begin
                    flip_reg[k] <= ang[k][15] ^ ang[k][14];
                    x_reg[k] <= tmb_pkg::CordicGain;
                    y_reg[k] <= '0;
                    z_reg[k] <= {ang[k][15] ^ (ang[k][15] ^ ang[k][14]), ang[k][14:0], 16'd0};
                end
                else if (step_reg <= CordLastStep)
                begin
                    if (!z_reg[k][31])
                    begin
                        x_reg[k] <= x_reg[k] - (y_reg[k] >>> (step_reg - 5'd1));
                        y_reg[k] <= y_reg[k] + (x_reg[k] >>> (step_reg - 5'd1));
                        z_reg[k] <= z_reg[k] - tmb_pkg::atan_turn(step_reg - 5'd1);
                    end
                    else
                    begin
                        x_reg[k] <= x_reg[k] + (y_reg[k] >>> (step_reg - 5'd1));
                        y_reg[k] <= y_reg[k] - (x_reg[k] >>> (step_reg - 5'd1));
                        z_reg[k] <= z_reg[k] + tmb_pkg::atan_turn(step_reg - 5'd1);
                    end
                end
            end
            if (step_reg == CordDoneStep)
            begin
                p1_reg[0] <= tmb_pkg::mul30(sh, sp);
                p1_reg[1] <= tmb_pkg::mul30(ch, sp);
            end
        end
        if (state_reg == ST_PROD)
        begin
            res_reg.rot[0] <= tmb_pkg::to_q28(36'(tmb_pkg::mul30(ch, cb))
                + 36'(tmb_pkg::mul30(p1_reg[0], sb)));
            res_reg.rot[1] <= tmb_pkg::to_q28(36'(tmb_pkg::mul30(sb, cp)));
            res_reg.rot[2] <= tmb_pkg::to_q28(-36'(tmb_pkg::mul30(sh, cb))
                + 36'(tmb_pkg::mul30(p1_reg[1], sb)));
            res_reg.rot[3] <= tmb_pkg::to_q28(-36'(tmb_pkg::mul30(ch, sb))
                + 36'(tmb_pkg::mul30(p1_reg[0], cb)));
            res_reg.rot[4] <= tmb_pkg::to_q28(36'(tmb_pkg::mul30(cb, cp)));
            res_reg.rot[5] <= tmb_pkg::to_q28(36'(tmb_pkg::mul30(sb, sh))
                + 36'(tmb_pkg::mul30(p1_reg[1], cb)));
            res_reg.rot[6] <= tmb_pkg::to_q28(36'(tmb_pkg::mul30(sh, cp)));
            res_reg.rot[7] <= tmb_pkg::to_q28(-36'(sp));
            res_reg.rot[8] <= tmb_pkg::to_q28(36'(tmb_pkg::mul30(ch, cp)));
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        rq_valid && rq_stall |=> rq_valid)
        else $error("front result dropped");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CORD && step_reg == CordDoneStep |=> state_reg == ST_PROD)
        else $error("cordic did not finish");
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_CORD || state_reg == ST_DONE)
        else $error("bad start");

endmodule

>>> sv/tmb_queue.sv
// Two-entry queue between front and back parts. Uses tmb_pkg.
module tmb_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_valid,
    output logic               wr_stall,
    input  tmb_pkg::rot_item_t wr_item,
    output logic               rd_valid,
    input  logic               rd_stall,
    output tmb_pkg::rot_item_t rd_item
);

    tmb_pkg::rot_item_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_stall = cnt_reg == 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_item  = mem_reg[rp_reg];
    assign wr = wr_valid && !wr_stall;
    assign rd = rd_valid && !rd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wp_reg] <= wr_item;
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid && rd_stall |=> rd_valid)
        else $error("queue entry lost");
    assert property (@(posedge clk) disable iff (!rst_n)
        wr && !rd |=> rd_valid)
        else $error("queue write lost");

endmodule

>>> sv/tmb_back.sv
// Back part: scales one rotation column per cycle while the output is not
// stalled and emits four column items per queued entry. Uses tmb_pkg.
module tmb_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rq_valid,
    output logic               rq_stall,
    input  tmb_pkg::rot_item_t rq_item,
    output logic               out_valid,
    input  logic               out_stall,
    output tmb_pkg::out_item_t out_item
);

    logic [1:0] col_reg;
    logic       ov_reg;
    tmb_pkg::out_item_t o_reg;
    logic adv;
    logic signed [31:0] sc;
    tmb_pkg::out_item_t o_next;

    function automatic logic [32:0] scale_elem(input tmb_pkg::q28_t r,
                                               input logic signed [31:0] s);
        logic signed [68:0] p;
        logic signed [42:0] v;
        logic sat;
        logic signed [31:0] res;
        p = r * s;
        v = 43'((p >>> 27) + 69'sd1) >>> 1;
        sat = 1'b0;
        res = v[31:0];
        if (v > 43'sd2147483647) begin res = 32'h7fffffff; sat = 1'b1; end
        if (v < -43'sd2147483648) begin res = 32'h80000000; sat = 1'b1; end
        return {sat, res};
    endfunction

    assign adv      = !ov_reg || !out_stall;
    assign rq_stall = !(adv && col_reg == 2'd3);
    assign out_valid = ov_reg;
    assign out_item  = o_reg;

    always_comb
    begin
        logic [32:0] e0, e1, e2;
        tmb_pkg::q28_t r0, r1, r2;
        case (col_reg)
            2'd0:
            begin
                sc = rq_item.scale_x;
                r0 = rq_item.rot[0]; r1 = rq_item.rot[1]; r2 = rq_item.rot[2];
            end
            2'd1:
            begin
                sc = rq_item.scale_y;
                r0 = rq_item.rot[3]; r1 = rq_item.rot[4]; r2 = rq_item.rot[5];
            end
            default:
            begin
                sc = rq_item.scale_z;
                r0 = rq_item.rot[6]; r1 = rq_item.rot[7]; r2 = rq_item.rot[8];
            end
        endcase
        e0 = scale_elem(r0, sc);
        e1 = scale_elem(r1, sc);
        e2 = scale_elem(r2, sc);
        o_next.column_index = col_reg;
        if (col_reg == 2'd3)
        begin
            o_next.elem_row0 = rq_item.trans_x;
            o_next.elem_row1 = rq_item.trans_y;
            o_next.elem_row2 = rq_item.trans_z;
            o_next.elem_row3 = tmb_pkg::OneQ16;
            o_next.saturated = 1'b0;
            o_next.last = 1'b1;
        end
        else
        begin
            o_next.elem_row0 = e0[31:0];
            o_next.elem_row1 = e1[31:0];
            o_next.elem_row2 = e2[31:0];
            o_next.elem_row3 = '0;
            o_next.saturated = e0[32] | e1[32] | e2[32];
            o_next.last = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= 2'd0;
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            ov_reg <= rq_valid;
            if (rq_valid) col_reg <= col_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && rq_valid) o_reg <= o_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_item))
        else $error("output changed under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.last == (out_item.column_index == 2'd3))
        else $error("last misplaced");
    assert property (@(posedge clk) disable iff (!rst_n)
        rq_valid && !rq_stall |-> col_reg == 2'd3)
        else $error("entry popped early");

endmodule
